### hw/rtl/ordered_list_engine_assert.svh
// Assertion macros used by the checker file of the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, idle during reset
`define OLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ordered list engine check failed");

// Next-cycle implication, idle during reset
`define OLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ordered list engine check failed");

`endif

### hw/rtl/olist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

    // List geometry
    localparam int CAPACITY  = 16;
    localparam int ITEM_BITS = 32;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    // Request codes
    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_INSERT = 3'd1;
    localparam logic [2:0] FN_REMOVE = 3'd2;
    localparam logic [2:0] FN_GET    = 3'd3;
    localparam logic [2:0] FN_INDEX  = 3'd4;
    localparam logic [2:0] FN_CLEAR  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef logic [ITEM_BITS-1:0] t_item;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  position;
        logic [31:0] item_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] item_out;
        logic [3:0]  found_position;
        logic [4:0]  entry_count;
    } t_rsp;

    // Store access issued by the sequencer
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_item            wr_data;
    } t_mem_ctl;

endpackage

`default_nettype wire

### hw/rtl/ordered_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to 16 items of 32 bits with append, insert-at, remove-at,
// get, index-of and clear. A request is taken when start is high and busy is
// low. Its single result appears on o_rsp for exactly one cycle with o_done
// high, and the receiver cannot stall it. Busy rises the cycle after a
// request is taken and drops as the result is loaded, so a new request may
// start in the same cycle that o_done is shown. Append, clear, bad requests and
// unused codes finish in the execute state; get reads the entry and returns it
// from a wait state. Insert-at moves entries up one place from the tail, then
// writes the new item; remove-at reads the removed item, then moves later
// entries down; index-of reads entries from the head until a match or the end.
// The store has a registered read, so the sequencer reads each moved or
// compared entry in one state and writes or compares it in another.
module ordered_list_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire olist_pkg::t_req i_req,
    output logic                 busy,
    output logic                 o_done,
    output olist_pkg::t_rsp      o_rsp
);

    olist_pkg::t_mem_ctl mem_ctl;
    olist_pkg::t_item    rd_data;
    logic                seq_busy;
    logic                accept;

    // Take a request only while the sequencer is idle
    assign accept = start & ~seq_busy;
    assign busy   = seq_busy;

    olist_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_req     (i_req),
        .i_rd_data (rd_data),
        .o_mem     (mem_ctl),
        .o_busy    (seq_busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp)
    );

    olist_mem u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

### hw/rtl/olist_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module olist_mem (
    input  wire logic               i_clk,
    input  wire olist_pkg::t_mem_ctl i_ctl,
    output olist_pkg::t_item        o_rd_data
);

    olist_pkg::t_item r_mem [olist_pkg::CAPACITY];
    olist_pkg::t_item r_rd_data;

    // Write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/olist_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module olist_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire olist_pkg::t_req     i_req,
    input  wire olist_pkg::t_item    i_rd_data,
    output olist_pkg::t_mem_ctl      o_mem,
    output logic                     o_busy,
    output logic                     o_done,
    output olist_pkg::t_rsp          o_rsp
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_RM_GET   = 4'd4;
    localparam logic [3:0] S_RM_RD    = 4'd5;
    localparam logic [3:0] S_RM_WR    = 4'd6;
    localparam logic [3:0] S_GET_WAIT = 4'd7;
    localparam logic [3:0] S_SC_RD    = 4'd8;
    localparam logic [3:0] S_SC_CMP   = 4'd9;

    logic [3:0]                        r_state, n_state;
    logic [2:0]                        r_func, n_func;
    logic [olist_pkg::IDX_W-1:0]       r_pos, n_pos;
    olist_pkg::t_item                  r_item, n_item;
    logic [olist_pkg::CNT_W-1:0]       r_count, n_count;
    logic [olist_pkg::CNT_W-1:0]       r_idx, n_idx;
    logic                              r_done, n_done;
    olist_pkg::t_rsp                   r_rsp, n_rsp;

    logic [olist_pkg::CNT_W-1:0]       idx_inc;
    logic [olist_pkg::CNT_W-1:0]       idx_dec;
    logic                              pos_bad;
    logic                              item_hit;
    logic                              fin;
    logic [1:0]                        fin_status;
    olist_pkg::t_item                  fin_item;
    logic [olist_pkg::IDX_W-1:0]       fin_found;

    assign idx_inc  = r_idx + olist_pkg::CNT_W'(1);
    assign idx_dec  = r_idx - olist_pkg::CNT_W'(1);
    assign pos_bad  = {1'b0, r_pos} >= r_count;
    // Shared comparator for the search walk
    assign item_hit = i_rd_data == r_item;

    // Sequence one request over the store
    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_pos      = r_pos;
        n_item     = r_item;
        n_count    = r_count;
        n_idx      = r_idx;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        o_mem      = '0;
        fin        = 1'b0;
        fin_status = olist_pkg::ST_OK;
        fin_item   = '0;
        fin_found  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_func  = i_req.func;
                    n_pos   = i_req.position;
                    n_item  = i_req.item_value[olist_pkg::ITEM_BITS-1:0];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_func)
                    olist_pkg::FN_APPEND: begin
                        if (r_count == olist_pkg::FULL_COUNT) begin
                            fin        = 1'b1;
                            fin_status = olist_pkg::ST_FULL;
                        end else begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr = r_count[olist_pkg::IDX_W-1:0];
                            o_mem.wr_data = r_item;
                            n_count       = r_count + olist_pkg::CNT_W'(1);
                            fin           = 1'b1;
                        end
                    end
                    olist_pkg::FN_INSERT: begin
                        if (pos_bad) begin
                            fin        = 1'b1;
                            fin_status = olist_pkg::ST_BADPOS;
                        end else if (r_count == olist_pkg::FULL_COUNT) begin
                            fin        = 1'b1;
                            fin_status = olist_pkg::ST_FULL;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_INS_RD;
                        end
                    end
                    olist_pkg::FN_REMOVE: begin
                        if (pos_bad) begin
                            fin        = 1'b1;
                            fin_status = olist_pkg::ST_BADPOS;
                        end else begin
                            o_mem.rd_en   = 1'b1;
                            o_mem.rd_addr = r_pos;
                            n_idx         = {1'b0, r_pos};
                            n_state       = S_RM_GET;
                        end
                    end
                    olist_pkg::FN_GET: begin
                        if (pos_bad) begin
                            fin        = 1'b1;
                            fin_status = olist_pkg::ST_BADPOS;
                        end else begin
                            o_mem.rd_en   = 1'b1;
                            o_mem.rd_addr = r_pos;
                            n_state       = S_GET_WAIT;
                        end
                    end
                    olist_pkg::FN_INDEX: begin
                        n_idx   = '0;
                        n_state = S_SC_RD;
                    end
                    olist_pkg::FN_CLEAR: begin
                        n_count = '0;
                        fin     = 1'b1;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            // Move entries up from the tail, then drop the new item in
            S_INS_RD: begin
                if (r_idx[olist_pkg::IDX_W-1:0] == r_pos) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_pos;
                    o_mem.wr_data = r_item;
                    n_count       = r_count + olist_pkg::CNT_W'(1);
                    fin           = 1'b1;
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = idx_dec[olist_pkg::IDX_W-1:0];
                    n_state       = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_idx[olist_pkg::IDX_W-1:0];
                o_mem.wr_data = i_rd_data;
                n_idx         = idx_dec;
                n_state       = S_INS_RD;
            end
            // Hold the removed item, then move later entries down
            S_RM_GET: begin
                n_item  = i_rd_data;
                n_state = S_RM_RD;
            end
            S_RM_RD: begin
                if (idx_inc >= r_count) begin
                    n_count  = r_count - olist_pkg::CNT_W'(1);
                    fin      = 1'b1;
                    fin_item = r_item;
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = idx_inc[olist_pkg::IDX_W-1:0];
                    n_state       = S_RM_WR;
                end
            end
            S_RM_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_idx[olist_pkg::IDX_W-1:0];
                o_mem.wr_data = i_rd_data;
                n_idx         = idx_inc;
                n_state       = S_RM_RD;
            end
            S_GET_WAIT: begin
                fin      = 1'b1;
                fin_item = i_rd_data;
            end
            // Walk the list from the head until a match or the end
            S_SC_RD: begin
                if (r_idx >= r_count) begin
                    fin        = 1'b1;
                    fin_status = olist_pkg::ST_NOTFOUND;
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_idx[olist_pkg::IDX_W-1:0];
                    n_state       = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                if (item_hit) begin
                    fin       = 1'b1;
                    fin_found = r_idx[olist_pkg::IDX_W-1:0];
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SC_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result and return to idle
        if (fin) begin
            n_state              = S_IDLE;
            n_done               = 1'b1;
            n_rsp.status         = fin_status;
            n_rsp.item_out       = 32'(fin_item);
            n_rsp.found_position = fin_found;
            n_rsp.entry_count    = n_count;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_pos  <= n_pos;
        r_item <= n_item;
        r_idx  <= n_idx;
        r_rsp  <= n_rsp;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

### hw/rtl/olist_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_list_engine_assert.svh"

module olist_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire logic            o_done,
    input wire olist_pkg::t_rsp o_rsp
);

    // A taken request makes the block busy
    `OLE_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy)
    // One result per request: never two strobes in a row
    `OLE_ASSERT_NEXT(a_single_done, i_clk, i_rst_n, o_done, !o_done)
    // Busy drops only as a result is shown
    `OLE_ASSERT_NOW(a_fall_done, i_clk, i_rst_n, $fell(busy), o_done)
    // A full status reports a full list
    `OLE_ASSERT_NOW(a_full_count, i_clk, i_rst_n,
        o_done && o_rsp.status == olist_pkg::ST_FULL,
        o_rsp.entry_count == olist_pkg::FULL_COUNT)
    // The count never passes capacity
    `OLE_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, o_done,
        o_rsp.entry_count <= olist_pkg::FULL_COUNT)

endmodule

bind ordered_list_engine olist_checker u_olist_checker (.*);

`default_nettype wire
